/* design/zpbf_pkg.sv */
// Shared types, coefficients and arithmetic helpers of the zero-phase band-pass filter.
`timescale 1ns / 1ps

package zpbf_pkg;

    // Filter coefficients in Q3.28. b1 and b3 are zero and b4 equals b0.
    localparam logic signed [31:0] C_B0     = 32'sd31867896;
    localparam logic signed [31:0] C_B0_NEG = -32'sd31867896;
    localparam logic signed [31:0] C_B2     = -32'sd63735793;
    localparam logic signed [31:0] C_A1     = -32'sd848111972;
    localparam logic signed [31:0] C_A2     = 32'sd998634569;
    localparam logic signed [31:0] C_A3     = -32'sd519320834;
    localparam logic signed [31:0] C_A4     = 32'sd100647961;

    localparam logic signed [47:0] C_S48_MAX = {1'b0, {47{1'b1}}};
    localparam logic signed [47:0] C_S48_MIN = {1'b1, {47{1'b0}}};

    // Multiply-accumulate steps of one element, in issue order.
    typedef enum logic [2:0] {
        OP_LOAD_NEG = 3'd0,
        OP_LOAD_POS = 3'd1,
        OP_B0       = 3'd2,
        OP_B2       = 3'd3,
        OP_A1       = 3'd4,
        OP_A2       = 3'd5,
        OP_A3       = 3'd6,
        OP_A4       = 3'd7
    } t_op;

    typedef struct packed {
        logic load_x;
        logic mul;
        logic acc;
        t_op  op;
    } t_mac_ctrl;

    function automatic logic signed [47:0] sat48(input logic signed [49:0] v);
        logic signed [47:0] r;
        if (v > 50'(C_S48_MAX)) begin
            r = C_S48_MAX;
        end else if (v < 50'(C_S48_MIN)) begin
            r = C_S48_MIN;
        end else begin
            r = v[47:0];
        end
        return r;
    endfunction

    // Q.20 state value to a Q.8 signal, rounded and saturated to 32 bits.
    function automatic logic signed [31:0] to_signal(input logic signed [47:0] y);
        logic signed [48:0] t;
        logic signed [36:0] s;
        logic signed [31:0] r;
        t = 49'(y) + 49'sd2048;
        s = 37'(t >>> 12);
        if (s > 37'sd2147483647) begin
            r = 32'sh7fffffff;
        end else if (s < -37'sd2147483648) begin
            r = 32'sh80000000;
        end else begin
            r = s[31:0];
        end
        return r;
    endfunction

    // Q.20 value to the rounded, saturated 16-bit output sample.
    function automatic logic signed [15:0] to_out16(input logic signed [47:0] y);
        logic signed [48:0] t;
        logic signed [28:0] s;
        logic signed [15:0] r;
        t = 49'(y) + 49'sd524288;
        s = 29'(t >>> 20);
        if (s > 29'sd32767) begin
            r = 16'sh7fff;
        end else if (s < -29'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = s[15:0];
        end
        return r;
    endfunction

endpackage

/* design/zpbf_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
`timescale 1ns / 1ps

module zpbf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* design/zpbf_mac.sv */
// Shared multiplier and filter state update of the IIR section.
`timescale 1ns / 1ps

module zpbf_mac import zpbf_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_mac_ctrl          i_ctrl,
    input  logic signed [31:0] i_x,
    output logic signed [31:0] o_y8,
    output logic signed [47:0] o_y20
);

    logic signed [31:0] r_x;
    logic signed [31:0] r_y8;
    logic signed [47:0] r_y20;
    logic signed [47:0] r_p0;
    logic signed [47:0] r_pb2;
    logic signed [63:0] r_prod;
    t_op                r_op;
    logic signed [47:0] r_z [4];

    logic signed [31:0] coef;
    logic signed [31:0] opnd;
    logic signed [47:0] q;
    logic signed [47:0] y20_new;

    always_comb begin
        case (i_ctrl.op)
            OP_LOAD_NEG: coef = C_B0_NEG;
            OP_LOAD_POS: coef = C_B0;
            OP_B0:       coef = C_B0;
            OP_B2:       coef = C_B2;
            OP_A1:       coef = C_A1;
            OP_A2:       coef = C_A2;
            OP_A3:       coef = C_A3;
            OP_A4:       coef = C_A4;
            default:     coef = C_B0;
        endcase
        if (i_ctrl.op == OP_A1 || i_ctrl.op == OP_A2 ||
            i_ctrl.op == OP_A3 || i_ctrl.op == OP_A4) begin
            opnd = r_y8;
        end else begin
            opnd = r_x;
        end
    end

    // Q.36 product rounded to Q.20.
    assign q       = 48'((r_prod + 64'sd32768) >>> 16);
    assign y20_new = sat48(50'(q) + 50'(r_z[0]));

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load_x) begin
            r_x <= i_x;
        end
        if (i_ctrl.mul) begin
            r_prod <= 64'(coef) * 64'(opnd);
            r_op   <= i_ctrl.op;
        end
        if (i_ctrl.acc) begin
            if (r_op == OP_B0) begin
                r_p0  <= q;
                r_y20 <= y20_new;
                r_y8  <= to_signal(y20_new);
            end
            if (r_op == OP_B2) begin
                r_pb2 <= q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 4; i++) begin
                r_z[i] <= '0;
            end
        end else if (i_ctrl.acc) begin
            case (r_op)
                OP_LOAD_NEG: begin
                    r_z[0] <= q;
                    r_z[1] <= q;
                end
                OP_LOAD_POS: begin
                    r_z[2] <= q;
                    r_z[3] <= q;
                end
                OP_A1:   r_z[0] <= sat48(50'(r_z[1]) - 50'(q));
                OP_A2:   r_z[1] <= sat48(50'(r_pb2) + 50'(r_z[2]) - 50'(q));
                OP_A3:   r_z[2] <= sat48(50'(r_z[3]) - 50'(q));
                OP_A4:   r_z[3] <= sat48(50'(r_p0) - 50'(q));
                default: ;
            endcase
        end
    end

    assign o_y8  = r_y8;
    assign o_y20 = r_y20;

endmodule

/* design/zero_phase_bandpass_filter_top.sv */
// Top level of the zero-phase band-pass filter: record stores, sequencer and output register.
`timescale 1ns / 1ps

// The block collects one record of signed 16-bit samples and returns it
// filtered forward and backward by a fixed fourth-order band-pass IIR.
// Input words arrive on the s_axis channel. With tuser low a word pushes a
// sample; tlast marks the last sample of the record and starts the
// computation. Samples beyond MAX_SAMPLES are dropped, but their tlast still
// ends the record. With tuser high a word requests the next filtered sample,
// which appears on the m_axis channel with tlast on the last one of the
// record. A request with no record ready, or past its end, returns nothing.
// A push after a finished record starts a new one.
// The computation visits each of the N + 2*PAD padded elements twice, once
// per pass, through a single shared 32x32 multiplier. Each element is read,
// loaded, then multiplied and accumulated step by step; each pass opens with
// the state load steps. s_axis_tready stays low throughout. A read passes
// through the registered read of the result RAM and the output register.
// While a result waits on a stalled m_axis, pushes and reads are held off;
// the result stays in the output register until taken. Reset clears the
// count, the read pointer, the filter state and the output valid; the RAMs
// keep their contents, which are always written before they are read.
module zero_phase_bandpass_filter_top import zpbf_pkg::*; #(
    parameter int MAX_SAMPLES = 1024,
    parameter int PAD         = 15
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    input  logic        s_axis_tuser,   // [0] func: 0 push, 1 read request
    input  logic        s_axis_tlast,   // sample_last
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] filtered
    output logic        m_axis_tlast    // out_last
);

    localparam int EXT  = MAX_SAMPLES + 2 * PAD;
    localparam int CW   = $clog2(MAX_SAMPLES + 1);
    localparam int KW   = $clog2(EXT + 1);
    localparam int SAW  = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
    localparam int PAW  = (EXT > 1) ? $clog2(EXT) : 1;
    localparam int PAD2 = 2 * PAD;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_RD   = 6'b000010,
        ST_LDX  = 6'b000100,
        ST_MUL  = 6'b001000,
        ST_ACC  = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_ridx, n_ridx;
    logic          r_ready, n_ready;
    logic          r_pass, n_pass;
    logic [KW-1:0] r_k, n_k;
    t_op           r_op, n_op;
    logic          r_ovalid, n_ovalid;
    logic          r_olast, n_olast;
    logic          r_plast, n_plast;
    logic [15:0]   r_odata, n_odata;

    logic          push_acc;
    logic          read_acc;
    logic [CW-1:0] base_count;
    logic [KW-1:0] count_k;
    logic [KW-1:0] len_k;
    logic [KW-1:0] ext_idx;
    logic [KW-1:0] pass_idx;
    logic [KW-1:0] out_idx;

    logic              s_we;
    logic [15:0]       s_rdata;
    logic              p_we;
    logic [PAW-1:0]    p_raddr;
    logic [31:0]       p_wdata;
    logic [31:0]       p_rdata;
    logic signed [31:0] mac_x;
    logic signed [31:0] y8;
    logic signed [47:0] y20;
    t_mac_ctrl          ctrl;

    assign s_axis_tready = (r_state == ST_IDLE) && (!r_ovalid || m_axis_tready);
    assign push_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
    assign read_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser;

    // A push after a finished record restarts the count.
    assign base_count = r_ready ? '0 : r_count;
    assign s_we       = push_acc && (base_count < CW'(MAX_SAMPLES));

    assign count_k = KW'(r_count);
    assign len_k   = count_k + KW'(PAD2);

    // Padded record index: edge samples repeat PAD times at each end.
    always_comb begin
        if (r_k < KW'(PAD)) begin
            ext_idx = '0;
        end else if (r_k < KW'(PAD) + count_k) begin
            ext_idx = r_k - KW'(PAD);
        end else begin
            ext_idx = count_k - KW'(1);
        end
    end

    assign pass_idx = r_pass ? (len_k - KW'(1) - r_k) : r_k;
    assign out_idx  = KW'(r_ridx) + KW'(PAD);
    assign p_raddr  = (r_state == ST_IDLE) ? out_idx[PAW-1:0] : pass_idx[PAW-1:0];

    assign p_we    = (r_state == ST_ACC) && (r_op == OP_A4);
    assign p_wdata = r_pass ? 32'(signed'(to_out16(y20))) : y8;

    assign mac_x = r_pass ? signed'(p_rdata)
                          : signed'({{8{s_rdata[15]}}, s_rdata, 8'h00});

    always_comb begin
        ctrl.load_x = (r_state == ST_LDX);
        ctrl.mul    = (r_state == ST_MUL);
        ctrl.acc    = (r_state == ST_ACC);
        ctrl.op     = r_op;
    end

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_ridx   = r_ridx;
        n_ready  = r_ready;
        n_pass   = r_pass;
        n_k      = r_k;
        n_op     = r_op;
        n_ovalid = r_ovalid;
        n_olast  = r_olast;
        n_plast  = r_plast;
        n_odata  = r_odata;

        if (m_axis_tready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            ST_IDLE: begin
                if (push_acc) begin
                    n_ready = 1'b0;
                    n_ridx  = '0;
                    n_count = s_we ? base_count + CW'(1) : base_count;
                    if (s_axis_tlast) begin
                        n_pass  = 1'b0;
                        n_k     = '0;
                        n_state = ST_RD;
                    end
                end else if (read_acc && r_ready && (r_ridx < r_count)) begin
                    n_plast = (r_ridx == r_count - CW'(1));
                    n_ridx  = r_ridx + CW'(1);
                    n_state = ST_OUT;
                end
            end
            ST_RD: begin
                n_state = ST_LDX;
            end
            ST_LDX: begin
                n_op    = (r_k == '0) ? OP_LOAD_NEG : OP_B0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_state = ST_ACC;
            end
            ST_ACC: begin
                if (r_op == OP_A4) begin
                    if (r_k == len_k - KW'(1)) begin
                        n_k = '0;
                        if (!r_pass) begin
                            n_pass  = 1'b1;
                            n_state = ST_RD;
                        end else begin
                            n_ready = 1'b1;
                            n_ridx  = '0;
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_k     = r_k + KW'(1);
                        n_state = ST_RD;
                    end
                end else begin
                    n_op    = t_op'(r_op + 3'd1);
                    n_state = ST_MUL;
                end
            end
            ST_OUT: begin
                n_odata  = p_rdata[15:0];
                n_olast  = r_plast;
                n_ovalid = 1'b1;
                n_state  = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_ridx   <= '0;
            r_ready  <= 1'b0;
            r_pass   <= 1'b0;
            r_k      <= '0;
            r_op     <= OP_LOAD_NEG;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_ridx   <= n_ridx;
            r_ready  <= n_ready;
            r_pass   <= n_pass;
            r_k      <= n_k;
            r_op     <= n_op;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_olast <= n_olast;
        r_plast <= n_plast;
        r_odata <= n_odata;
    end

    zpbf_ram #(
        .WIDTH (16),
        .DEPTH (MAX_SAMPLES)
    ) u_sample_ram (
        .i_clk   (i_clk),
        .i_we    (s_we),
        .i_waddr (base_count[SAW-1:0]),
        .i_wdata (s_axis_tdata),
        .i_raddr (ext_idx[SAW-1:0]),
        .o_rdata (s_rdata)
    );

    zpbf_ram #(
        .WIDTH (32),
        .DEPTH (EXT)
    ) u_pass_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (pass_idx[PAW-1:0]),
        .i_wdata (p_wdata),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    zpbf_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (ctrl),
        .i_x     (mac_x),
        .o_y8    (y8),
        .o_y20   (y20)
    );

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tlast  = r_olast;

`ifndef SYNTHESIS
    a_rose_after_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovalid) |-> $past(r_state == ST_OUT))
        else $error("output word appeared without a result read");

    a_ridx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ridx <= r_count)
        else $error("read pointer ran past the record");

    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ACC) |-> $past(r_state == ST_MUL))
        else $error("accumulate step without a product");
`endif

endmodule

/* tb/zero_phase_bandpass_filter_top_tb.sv */
// Self-checking testbench of the zero-phase band-pass filter top level.
`timescale 1ns / 1ps

// Records of signed samples are pushed on s_axis and read back on m_axis.
// A scoreboard class recomputes each record with a forward and a backward
// pass of the same fixed-point filter and checks every returned word in
// order. The sender works in random bursts, and the receiver stalls on a
// changing pattern. Directed records cover the sample extremes, reads with
// no record ready or past the end, a one-sample record and a new record that
// discards an old one. Random records of varied length follow.
module zero_phase_bandpass_filter_top_tb;
    import zpbf_pkg::*;

    localparam int MAX_SAMPLES = 1024;
    localparam int PAD         = 15;
    localparam int EXT_LEN     = MAX_SAMPLES + 2 * PAD;
    localparam bit FUNC_PUSH   = 1'b0;
    localparam bit FUNC_READ   = 1'b1;

    // Scoreboard: a bit-true copy of the filter and the queue of expected words.
    class filter_scoreboard;
        typedef struct {
            logic [15:0] filtered;
            bit          last;
        } t_expected;

        localparam longint S48_MAX = 64'sd140737488355327;
        localparam longint S48_MIN = -64'sd140737488355328;

        shortint   samples[MAX_SAMPLES];
        int        pass_buf[EXT_LEN];
        longint    zst[4];
        longint    coef_b[5];
        longint    coef_a[5];
        int        count;
        int        rd_ptr;
        bit        ready;
        t_expected pending_q[$];
        int        mismatches;

        function new();
            coef_b = '{longint'(C_B0), 0, longint'(C_B2), 0, longint'(C_B0)};
            coef_a = '{0, longint'(C_A1), longint'(C_A2), longint'(C_A3), longint'(C_A4)};
            count      = 0;
            rd_ptr     = 0;
            ready      = 0;
            mismatches = 0;
        endfunction

        function longint clamp(longint v, longint lo, longint hi);
            return v < lo ? lo : (v > hi ? hi : v);
        endfunction

        // Coefficient times signal, Q.36 rounded down to Q.20.
        function longint qmul(longint c, longint s);
            return (c * s + 64'sd32768) >>> 16;
        endfunction

        function longint q20_to_q8(longint y20);
            return clamp((y20 + 64'sd2048) >>> 12, -64'sd2147483648, 64'sd2147483647);
        endfunction

        // Steady-state start, unit state {-b0, -b0, b0, b0} scaled by x.
        function void seed_state(longint x8);
            zst[0] = clamp(qmul(-coef_b[0], x8), S48_MIN, S48_MAX);
            zst[1] = clamp(qmul(-coef_b[0], x8), S48_MIN, S48_MAX);
            zst[2] = clamp(qmul(coef_b[0], x8), S48_MIN, S48_MAX);
            zst[3] = clamp(qmul(coef_b[0], x8), S48_MIN, S48_MAX);
        endfunction

        function longint iir_step(longint x8);
            longint y20;
            longint y8;
            y20 = clamp(qmul(coef_b[0], x8) + zst[0], S48_MIN, S48_MAX);
            y8  = q20_to_q8(y20);
            for (int j = 1; j < 4; j++) begin
                zst[j-1] = clamp(qmul(coef_b[j], x8) + zst[j] - qmul(coef_a[j], y8),
                                 S48_MIN, S48_MAX);
            end
            zst[3] = clamp(qmul(coef_b[4], x8) - qmul(coef_a[4], y8), S48_MIN, S48_MAX);
            return y20;
        endfunction

        // Padded record: the edge samples repeat PAD times at each end.
        function longint padded(int k);
            int i;
            if (k < PAD) begin
                i = 0;
            end else if (k < PAD + count) begin
                i = k - PAD;
            end else begin
                i = count - 1;
            end
            return longint'(samples[i]) * 256;
        endfunction

        function void filter_record();
            int     len;
            int     idx;
            longint y20;
            len = count + 2 * PAD;
            seed_state(padded(0));
            for (int k = 0; k < len; k++) begin
                pass_buf[k] = int'(q20_to_q8(iir_step(padded(k))));
            end
            seed_state(longint'(pass_buf[len-1]));
            for (int k = 0; k < len; k++) begin
                idx = len - 1 - k;
                y20 = iir_step(longint'(pass_buf[idx]));
                pass_buf[idx] = int'(clamp((y20 + 64'sd524288) >>> 20, -64'sd32768,
                                           64'sd32767));
            end
        endfunction

        function void note_input(bit func, logic [15:0] smp, bit lst);
            t_expected e;
            if (func == FUNC_PUSH) begin
                if (ready) begin
                    ready  = 0;
                    count  = 0;
                    rd_ptr = 0;
                end
                if (count < MAX_SAMPLES) begin
                    samples[count] = shortint'(smp);
                    count++;
                end
                if (lst) begin
                    filter_record();
                    ready  = 1;
                    rd_ptr = 0;
                end
            end else if (ready && rd_ptr < count) begin
                e.filtered = pass_buf[PAD + rd_ptr][15:0];
                e.last     = (rd_ptr == count - 1);
                pending_q.push_back(e);
                rd_ptr++;
            end
        endfunction

        function void check_result(logic [15:0] data, logic lst);
            t_expected e;
            if (pending_q.size() == 0) begin
                if (mismatches < 10) begin
                    $display("%0t: unexpected word data=%h last=%b", $realtime, data, lst);
                end
                mismatches++;
                return;
            end
            e = pending_q.pop_front();
            if (data !== e.filtered || lst !== e.last) begin
                if (mismatches < 10) begin
                    $display("%0t: mismatch: expected data=%h last=%b, got data=%h last=%b",
                             $realtime, e.filtered, e.last, data, lst);
                end
                mismatches++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;     // [15:0] sample
    logic        s_axis_tuser = 1'b0;   // [0] func
    logic        s_axis_tlast = 1'b0;   // sample_last
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // [15:0] filtered
    logic        m_axis_tlast;          // out_last

    filter_scoreboard sb = new();

    int   burst_left = 8;
    int   words_sent = 0;
    logic [7:0] stall_pat = 8'hff;
    int   stall_cnt = 0;

    zero_phase_bandpass_filter_top #(
        .MAX_SAMPLES(MAX_SAMPLES),
        .PAD        (PAD)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .s_axis_tlast (s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tlast (m_axis_tlast)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Both channels are observed at the clock edge, before the edge's updates land.
    always @(posedge i_clk) begin
        if (i_rst_n && s_axis_tvalid && s_axis_tready) begin
            sb.note_input(s_axis_tuser, s_axis_tdata, s_axis_tlast);
        end
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_result(m_axis_tdata, m_axis_tlast);
        end
    end

    // The receiver walks an 8-bit ready pattern and redraws it periodically;
    // about a third of the patterns never stall.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= stall_pat[stall_cnt % 8];
            stall_cnt = stall_cnt + 1;
            if (stall_cnt % 64 == 0) begin
                stall_pat = ($urandom_range(0, 2) == 0) ? 8'hff : 8'($urandom);
            end
        end
    end

    // One word on s_axis; after each burst the sender idles for a random gap.
    task automatic send_word(bit func, logic [15:0] smp, bit lst);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= func;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        @(posedge i_clk);
        while (!s_axis_tready) begin
            @(posedge i_clk);
        end
        words_sent++;
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap = $urandom_range(1, 12);
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic push_sample(logic [15:0] smp, bit lst);
        send_word(FUNC_PUSH, smp, lst);
    endtask

    // The data and last bits of a read request are don't-care, so they are randomized.
    task automatic request_word();
        send_word(FUNC_READ, 16'($urandom), 1'($urandom));
    endtask

    // The queue is not polled until the last accepted word has been noted.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (sb.pending_q.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random samples lean toward the extremes now and then to reach saturation.
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(0, 5))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            2:       return 16'($signed($urandom_range(0, 200)) - 100);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic run_record(int n, int reads);
        for (int i = 0; i < n; i++) begin
            push_sample(pick_sample(), i == n - 1);
        end
        for (int i = 0; i < reads; i++) begin
            request_word();
        end
    endtask

    initial begin
        int n;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reads before any record exists return nothing.
        request_word();
        request_word();

        // One-sample record at the positive extreme, with a read past its end.
        push_sample(16'h7fff, 1'b1);
        request_word();
        request_word();

        // Alternating extremes; the push starts a new record over the finished one.
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h8000, 1'b0);
        push_sample(16'h7fff, 1'b0);
        push_sample(16'h0000, 1'b1);
        repeat (6) request_word();

        // A partly read record is discarded by the next one.
        push_sample(16'h0001, 1'b0);
        push_sample(16'hffff, 1'b0);
        push_sample(16'h8000, 1'b1);
        request_word();
        push_sample(16'h1234, 1'b0);
        push_sample(16'hedcb, 1'b1);
        repeat (3) request_word();

        // Hold off until every expected word has come back.
        wait_drained();

        while (words_sent < 780) begin
            case ($urandom_range(0, 9))
                0: begin
                    // Noise: stray reads and a record that may be read only in part.
                    repeat ($urandom_range(1, 4)) request_word();
                    n = $urandom_range(1, 8);
                    run_record(n, $urandom_range(0, n));
                end
                1: begin
                    n = $urandom_range(40, 120);
                    run_record(n, n + 1);
                end
                default: begin
                    n = $urandom_range(1, 24);
                    run_record(n, n + $urandom_range(0, 1));
                end
            endcase
            if ($urandom_range(0, 15) == 0) begin
                wait_drained();
            end
        end

        n = $urandom_range(2, 10);
        run_record(n, n + 1);

        wait_drained();
        repeat (200) @(posedge i_clk);
        if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule
